// ----- hw/rtl/prss_pkg.sv -----
package prss_pkg;

    // Field widths of the input and result words
    localparam int BASE_W  = 52;
    localparam int COUNT_W = 41;
    localparam int IDX_W   = 3;
    localparam int RBASE_W = 53;
    localparam int PAGES_W = 41;
    localparam int BYTES_W = 31;

    // Physical address bits honored in base_address
    localparam int ADDR_BITS = 52;

    localparam logic [BASE_W-1:0] ADDR_MASK =
        (ADDR_BITS >= BASE_W) ? {BASE_W{1'b1}} :
        BASE_W'((64'd1 << ADDR_BITS) - 64'd1);

    // Page count saturation limit: 2^40 pages
    localparam logic [COUNT_W-1:0] MAX_PAGES = COUNT_W'(64'd1 << 40);

    // Page sizes in bytes
    localparam logic [BYTES_W-1:0] BYTES_4K = BYTES_W'(32'd4096);
    localparam logic [BYTES_W-1:0] BYTES_2M = BYTES_W'(32'd2097152);
    localparam logic [BYTES_W-1:0] BYTES_1G = BYTES_W'(32'd1073741824);

    // Run codes in emit order
    localparam int RUN_COUNT = 5;
    localparam logic [IDX_W-1:0] RUN_1G_MID  = 3'd0;
    localparam logic [IDX_W-1:0] RUN_2M_LOW  = 3'd1;
    localparam logic [IDX_W-1:0] RUN_2M_HIGH = 3'd2;
    localparam logic [IDX_W-1:0] RUN_4K_HEAD = 3'd3;
    localparam logic [IDX_W-1:0] RUN_4K_TAIL = 3'd4;

    typedef struct packed {
        logic [RBASE_W-1:0] base;
        logic [PAGES_W-1:0] pages;
        logic [BYTES_W-1:0] bytes;
    } run_t;

    // Range bounds after the address add stage
    typedef struct packed {
        logic [RBASE_W-1:0] s;
        logic [RBASE_W-1:0] e;
        logic [RBASE_W-1:0] u2;
        logic [RBASE_W-1:0] d2;
        logic [RBASE_W-1:0] u1;
        logic [RBASE_W-1:0] d1;
    } bounds_t;

endpackage

// ----- hw/rtl/page_range_size_splitter.sv -----
// Page range size splitter.
// Input stream (s_*): one word per range, base_address and page_count.
// Output stream (m_*): five words per range, run 0 (1GB middle), run 1
// (lower 2MB), run 2 (upper 2MB), run 3 (4KB head), run 4 (4KB tail);
// m_tlast marks run 4. Unused runs carry zero base, pages and page bytes.
// Pipeline: input register, bounds register (end address and 2MB/1GB
// roundings), run bank register holding all five runs, then the bank is
// read out one run per cycle by a run counter while m_tready is high.
// The first run is valid once the range has passed the input, bounds
// and run bank registers.
// The output channel moves one run per cycle while m_tready is high and
// so sets the rate of ranges; the input and bounds registers take the
// next ranges while the bank is still being read out.
// Reset clears all valid flags and the run counter; no word is pending.
// When the receiver holds m_tready low, the current run stays on m_tdata,
// and the bounds and input registers fill up before s_tready drops.
module page_range_size_splitter
    import prss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [51:0] base_address, [92:52] page_count, [95:93] zero
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] run_index, [55:3] run_base, [96:56] run_pages,
    // [127:97] run_page_bytes
    output logic [127:0] m_tdata,
    output logic         m_tlast
);

    // Input stage
    logic                 in_valid_reg;
    logic [RBASE_W-1:0]   start_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [RBASE_W-1:0]   start_next;
    logic [COUNT_W-1:0]   count_next;

    // Bounds stage
    logic                 bnd_valid_reg;
    bounds_t              bnd_reg;
    bounds_t              bnd_next;

    // Run bank and readout
    logic                 bank_valid_reg;
    run_t                 bank_reg [RUN_COUNT];
    run_t                 bank_next [RUN_COUNT];
    logic [IDX_W-1:0]     cnt_reg;

    logic                 out_fire;
    logic                 out_done;
    logic                 bank_load;
    logic                 bnd_load;
    logic                 in_load;

    logic [BASE_W-1:0]    in_base;
    logic [COUNT_W-1:0]   in_count;
    logic [RBASE_W-1:0]   mask_2m;
    logic [RBASE_W-1:0]   mask_1g;
    logic                 cross_2m;
    logic                 cross_1g;
    logic [RBASE_W-1:0]   diff_mid;
    logic [RBASE_W-1:0]   diff_low;
    logic [RBASE_W-1:0]   diff_high;
    logic [RBASE_W-1:0]   diff_span;
    logic [RBASE_W-1:0]   diff_head;
    logic [RBASE_W-1:0]   diff_tail;
    run_t                 cur_run;

    // Handshake chain
    assign out_fire  = m_tvalid && m_tready;
    assign out_done  = out_fire && (cnt_reg == RUN_4K_TAIL);
    assign bank_load = bnd_valid_reg && (!bank_valid_reg || out_done);
    assign bnd_load  = in_valid_reg && (!bnd_valid_reg || bank_load);
    assign in_load   = s_tvalid && s_tready;
    assign s_tready  = !in_valid_reg || bnd_load;

    // Mask the base to the page grid, saturate the count
    assign in_base  = s_tdata[BASE_W-1:0];
    assign in_count = s_tdata[BASE_W+COUNT_W-1:BASE_W];

    always_comb
    begin
        start_next = {1'b0, in_base & ADDR_MASK & ~BASE_W'(12'hFFF)};
        count_next = (in_count > MAX_PAGES) ? MAX_PAGES : in_count;
    end

    // End address and roundings to 2MB and 1GB
    assign mask_2m = ~RBASE_W'(21'h1FFFFF);
    assign mask_1g = ~RBASE_W'(30'h3FFFFFFF);

    always_comb
    begin
        bnd_next.s  = start_reg;
        bnd_next.e  = start_reg + {count_reg, 12'h000};
        bnd_next.u2 = (start_reg + RBASE_W'(21'h1FFFFF)) & mask_2m;
        bnd_next.d2 = bnd_next.e & mask_2m;
        bnd_next.u1 = (start_reg + RBASE_W'(30'h3FFFFFFF)) & mask_1g;
        bnd_next.d1 = bnd_next.e & mask_1g;
    end

    // Split into the five runs
    always_comb
    begin
        cross_2m  = bnd_reg.u2 <= bnd_reg.d2;
        cross_1g  = bnd_reg.u1 <= bnd_reg.d1;
        diff_mid  = bnd_reg.d1 - bnd_reg.u1;
        diff_low  = bnd_reg.u1 - bnd_reg.u2;
        diff_high = bnd_reg.d2 - bnd_reg.d1;
        diff_span = bnd_reg.d2 - bnd_reg.u2;
        diff_head = bnd_reg.u2 - bnd_reg.s;
        diff_tail = bnd_reg.e - bnd_reg.d2;

        for (int k = 0; k < RUN_COUNT; k++)
        begin
            bank_next[k] = '0;
        end

        if (cross_2m)
        begin
            if (cross_1g)
            begin
                bank_next[RUN_1G_MID].base   = bnd_reg.u1;
                bank_next[RUN_1G_MID].pages  = PAGES_W'(diff_mid[RBASE_W-1:30]);
                bank_next[RUN_1G_MID].bytes  = BYTES_1G;
                bank_next[RUN_2M_LOW].base   = bnd_reg.u2;
                bank_next[RUN_2M_LOW].pages  = PAGES_W'(diff_low[RBASE_W-1:21]);
                bank_next[RUN_2M_LOW].bytes  = BYTES_2M;
                bank_next[RUN_2M_HIGH].base  = bnd_reg.d1;
                bank_next[RUN_2M_HIGH].pages = PAGES_W'(diff_high[RBASE_W-1:21]);
                bank_next[RUN_2M_HIGH].bytes = BYTES_2M;
            end
            else
            begin
                bank_next[RUN_2M_HIGH].base  = bnd_reg.u2;
                bank_next[RUN_2M_HIGH].pages = PAGES_W'(diff_span[RBASE_W-1:21]);
                bank_next[RUN_2M_HIGH].bytes = BYTES_2M;
            end
            bank_next[RUN_4K_HEAD].base  = bnd_reg.s;
            bank_next[RUN_4K_HEAD].pages = diff_head[RBASE_W-1:12];
            bank_next[RUN_4K_HEAD].bytes = BYTES_4K;
            bank_next[RUN_4K_TAIL].base  = bnd_reg.d2;
            bank_next[RUN_4K_TAIL].pages = diff_tail[RBASE_W-1:12];
            bank_next[RUN_4K_TAIL].bytes = BYTES_4K;
        end
        else
        begin
            bank_next[RUN_4K_TAIL].base  = bnd_reg.s;
            bank_next[RUN_4K_TAIL].pages = PAGES_W'(bnd_reg.e[RBASE_W-1:12] -
                                                    bnd_reg.s[RBASE_W-1:12]);
            bank_next[RUN_4K_TAIL].bytes = BYTES_4K;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            bnd_valid_reg  <= 1'b0;
            bank_valid_reg <= 1'b0;
            cnt_reg        <= RUN_1G_MID;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (bnd_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (bnd_load)
            begin
                bnd_valid_reg <= 1'b1;
            end
            else if (bank_load)
            begin
                bnd_valid_reg <= 1'b0;
            end

            if (bank_load)
            begin
                bank_valid_reg <= 1'b1;
                cnt_reg        <= RUN_1G_MID;
            end
            else if (out_done)
            begin
                bank_valid_reg <= 1'b0;
                cnt_reg        <= RUN_1G_MID;
            end
            else if (out_fire)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            start_reg <= start_next;
            count_reg <= count_next;
        end
        if (bnd_load)
        begin
            bnd_reg <= bnd_next;
        end
        if (bank_load)
        begin
            for (int k = 0; k < RUN_COUNT; k++)
            begin
                bank_reg[k] <= bank_next[k];
            end
        end
    end

    // Read out the current run
    assign cur_run  = bank_reg[cnt_reg];
    assign m_tvalid = bank_valid_reg;
    assign m_tlast  = (cnt_reg == RUN_4K_TAIL);
    assign m_tdata  = {cur_run.bytes, cur_run.pages, cur_run.base, cnt_reg};

    // Run counter stays within the five runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RUN_4K_TAIL)
    else $error("run counter out of range");

    // A freshly loaded bank starts at the first run
    assert property (@(posedge clk) disable iff (!rst_n)
        bank_load |=> (cnt_reg == RUN_1G_MID) && bank_valid_reg)
    else $error("bank load did not restart readout");

    // Bank drains when the last run leaves and nothing waits behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_done && !bnd_valid_reg) |=> !bank_valid_reg)
    else $error("bank still valid after last run");

    // The tail run is always a 4KB run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (cur_run.bytes == BYTES_4K))
    else $error("tail run not 4KB");

    // A used 1GB run always comes with an upper 2MB run
    assert property (@(posedge clk) disable iff (!rst_n)
        (bank_valid_reg && (bank_reg[RUN_1G_MID].bytes != '0)) |->
        (bank_reg[RUN_2M_HIGH].bytes == BYTES_2M))
    else $error("1GB run without upper 2MB run");

endmodule
